>>> hdl/ehpe_pkg.sv
// Package for the exception-header pointer byte encoder: word types and encoding codes.
package ehpe_pkg;

  localparam int DEFAULT_POINTER_BYTES = 8;
  localparam int MAX_FIXED_BYTES       = 8;

  localparam logic [3:0] MODE_ABS     = 4'h0;
  localparam logic [3:0] MODE_PCREL   = 4'h1;
  localparam logic [3:0] MODE_TEXTREL = 4'h2;
  localparam logic [3:0] MODE_DATAREL = 4'h3;
  localparam logic [3:0] MODE_FUNCREL = 4'h4;

  localparam logic [3:0] FORM_NATIVE  = 4'h0;
  localparam logic [3:0] FORM_ULEB128 = 4'h1;
  localparam logic [3:0] FORM_UDATA2  = 4'h2;
  localparam logic [3:0] FORM_UDATA4  = 4'h3;
  localparam logic [3:0] FORM_UDATA8  = 4'h4;
  localparam logic [3:0] FORM_SLEB128 = 4'h9;
  localparam logic [3:0] FORM_SDATA2  = 4'hA;
  localparam logic [3:0] FORM_SDATA4  = 4'hB;
  localparam logic [3:0] FORM_SDATA8  = 4'hC;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic signed [63:0] pointer_value;
    logic [7:0]         encoding;
    logic [63:0]        position;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       status;
  } out_word_t;

endpackage

>>> hdl/eh_pointer_byte_encoder.sv
// Exception-header pointer encoder: streams the encoded pointer one byte per word.
//
//   channel | ports                      | direction | word
//   in      | in_valid in_ready in_data  | input     | ehpe_pkg::in_word_t
//   out     | out_valid out_ready out_data | output  | ehpe_pkg::out_word_t
//
// One input word yields 1 to 10 output words, one byte per cycle while not stalled,
// from a shift register of the (position-adjusted) value.
// The next input word is taken once the last byte of the current one is in the
// output register. Reset is synchronous; it clears control state only.
// A stalled out_ready holds the output register and stops the byte shift register.
module eh_pointer_byte_encoder #(
  parameter int POINTER_BYTES = ehpe_pkg::DEFAULT_POINTER_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ehpe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ehpe_pkg::out_word_t out_data
);

  localparam int CNT_W = $clog2(ehpe_pkg::MAX_FIXED_BYTES + 1);

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_FIXED,
    KIND_ULEB,
    KIND_SLEB
  } kind_t;

  logic                busy_r, busy_nxt;
  kind_t               kind_r, kind_nxt;
  logic [63:0]         val_r, val_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  ehpe_pkg::out_word_t out_data_r, out_data_nxt;

  logic        accept;
  logic        emit;
  logic [3:0]  mode;
  logic [3:0]  form;
  logic [63:0] adj_val;
  logic [63:0] shr7_u;
  logic [63:0] shr7_s;
  logic [6:0]  dig7;
  logic        more;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mode    = in_data.encoding[7:4];
  assign form    = in_data.encoding[3:0];
  assign adj_val = (mode == ehpe_pkg::MODE_ABS) ? in_data.pointer_value
                                                : in_data.pointer_value - in_data.position;

  assign dig7   = val_r[6:0];
  assign shr7_u = {7'b0, val_r[63:7]};
  assign shr7_s = {{7{val_r[63]}}, val_r[63:7]};

  always_comb begin
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    more          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      busy_nxt = 1'b1;
      val_nxt  = adj_val;
      cnt_nxt  = CNT_W'(ehpe_pkg::MAX_FIXED_BYTES);
      kind_nxt = KIND_ERR;
      if (mode inside {ehpe_pkg::MODE_ABS, ehpe_pkg::MODE_PCREL, ehpe_pkg::MODE_TEXTREL,
                       ehpe_pkg::MODE_DATAREL, ehpe_pkg::MODE_FUNCREL}) begin
        case (form)
          ehpe_pkg::FORM_NATIVE: begin
            kind_nxt = KIND_FIXED;
            cnt_nxt  = CNT_W'(POINTER_BYTES);
          end
          ehpe_pkg::FORM_UDATA2, ehpe_pkg::FORM_SDATA2: begin
            kind_nxt = KIND_FIXED;
            cnt_nxt  = CNT_W'(2);
          end
          ehpe_pkg::FORM_UDATA4, ehpe_pkg::FORM_SDATA4: begin
            kind_nxt = KIND_FIXED;
            cnt_nxt  = CNT_W'(4);
          end
          ehpe_pkg::FORM_UDATA8, ehpe_pkg::FORM_SDATA8: begin
            kind_nxt = KIND_FIXED;
            cnt_nxt  = CNT_W'(8);
          end
          ehpe_pkg::FORM_ULEB128: kind_nxt = KIND_ULEB;
          ehpe_pkg::FORM_SLEB128: kind_nxt = KIND_SLEB;
          default:                kind_nxt = KIND_ERR;
        endcase
      end
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      case (kind_r)
        KIND_FIXED: begin
          out_data_nxt.out_byte  = val_r[7:0];
          out_data_nxt.last_byte = (cnt_r == CNT_W'(1));
          out_data_nxt.status    = ehpe_pkg::STATUS_OK;
          val_nxt                = {8'b0, val_r[63:8]};
          cnt_nxt                = cnt_r - CNT_W'(1);
          busy_nxt               = (cnt_r != CNT_W'(1));
        end
        KIND_ULEB: begin
          more                   = (shr7_u != 64'b0);
          out_data_nxt.out_byte  = {more, dig7};
          out_data_nxt.last_byte = !more;
          out_data_nxt.status    = ehpe_pkg::STATUS_OK;
          val_nxt                = shr7_u;
          busy_nxt               = more;
        end
        KIND_SLEB: begin
          more = !(((shr7_s == 64'b0) && !dig7[6]) || ((shr7_s == '1) && dig7[6]));
          out_data_nxt.out_byte  = {more, dig7};
          out_data_nxt.last_byte = !more;
          out_data_nxt.status    = ehpe_pkg::STATUS_OK;
          val_nxt                = shr7_s;
          busy_nxt               = more;
        end
        default: begin
          out_data_nxt.out_byte  = 8'h00;
          out_data_nxt.last_byte = 1'b1;
          out_data_nxt.status    = ehpe_pkg::STATUS_ERR;
          busy_nxt               = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      kind_r      <= KIND_ERR;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // error words carry a zero byte and close the item
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> out_data_r.last_byte && out_data_r.out_byte == 8'h00)
    else $error("error word malformed");

  // a pending non-final byte keeps the input closed
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_byte |-> !in_ready)
    else $error("input taken mid-item");

  // LEB continuation bit set on every non-final byte
  a_leb_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_byte && (kind_r == KIND_ULEB || kind_r == KIND_SLEB)
    |-> out_data_r.out_byte[7])
    else $error("LEB continuation bit missing");

  // fixed-width count never runs out while busy
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && kind_r == KIND_FIXED |-> cnt_r != '0)
    else $error("fixed byte count underflow");

  // emitting the final byte frees the input on the next cycle
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !accept && out_data_nxt.last_byte |=> !busy_r)
    else $error("busy after final byte");

endmodule

>>> tb/ehpe_byte_checker.sv
`timescale 1ns / 100ps
// Checker for the pointer byte encoder: predicts the byte stream per input word and compares.
module ehpe_byte_checker
  import ehpe_pkg::*;
#(
  parameter int POINTER_BYTES = DEFAULT_POINTER_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending_bytes,
  output int        bytes_checked,
  output int        error_words
);

  out_word_t expected_bytes[$];
  int        mismatches = 0;
  int        checked    = 0;
  int        errors     = 0;

  function automatic void push_byte(logic [7:0] b, logic last, logic st);
    expected_bytes.push_back('{out_byte: b, last_byte: last, status: st});
  endfunction

  function automatic void push_fixed(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      push_byte(v[8*i +: 8], i == nbytes - 1, STATUS_OK);
    end
  endfunction

  function automatic void push_uleb(logic [63:0] v);
    logic [6:0] b;
    logic       more;
    more = 1'b1;
    while (more) begin
      b    = v[6:0];
      v    = v >> 7;
      more = (v != '0);
      push_byte({more, b}, !more, STATUS_OK);
    end
  endfunction

  function automatic void push_sleb(logic [63:0] v);
    logic [6:0] b;
    logic       more;
    more = 1'b1;
    while (more) begin
      b = v[6:0];
      v = $signed(v) >>> 7;
      if ((v == '0 && !b[6]) || (v == '1 && b[6])) more = 1'b0;
      push_byte({more, b}, !more, STATUS_OK);
    end
  endfunction

  function automatic void queue_encoded_bytes(in_word_t w);
    logic [63:0] v;
    logic [3:0]  mode;
    logic [3:0]  form;
    v    = w.pointer_value;
    mode = w.encoding[7:4];
    form = w.encoding[3:0];
    if (mode inside {MODE_PCREL, MODE_TEXTREL, MODE_DATAREL, MODE_FUNCREL}) begin
      v = v - w.position;
    end else if (mode != MODE_ABS) begin
      push_byte(8'h00, 1'b1, STATUS_ERR);
      return;
    end
    case (form)
      FORM_NATIVE:               push_fixed(v, POINTER_BYTES);
      FORM_ULEB128:              push_uleb(v);
      FORM_UDATA2, FORM_SDATA2:  push_fixed(v, 2);
      FORM_UDATA4, FORM_SDATA4:  push_fixed(v, 4);
      FORM_UDATA8, FORM_SDATA8:  push_fixed(v, 8);
      FORM_SLEB128:              push_sleb(v);
      default:                   push_byte(8'h00, 1'b1, STATUS_ERR);
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected word: byte %h last %b status %b", $realtime,
                     out_data.out_byte, out_data.last_byte, out_data.status);
          end
        end else begin
          want = expected_bytes.pop_front();
          checked++;
          if (want.status == STATUS_ERR) errors++;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected byte %h last %b status %b, got byte %h last %b status %b",
                       $realtime, want.out_byte, want.last_byte, want.status,
                       out_data.out_byte, out_data.last_byte, out_data.status);
            end
          end
        end
      end
      if (in_valid && in_ready) queue_encoded_bytes(in_data);
    end
    fail_count    <= mismatches;
    pending_bytes <= expected_bytes.size();
    bytes_checked <= checked;
    error_words   <= errors;
  end

endmodule

>>> tb/eh_pointer_byte_encoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the pointer byte encoder: stimulus, output stalls and the verdict.
module eh_pointer_byte_encoder_tb;
  import ehpe_pkg::*;

  localparam int NUM_RANDOM = 142;

  localparam logic [3:0] MODE_ALIGNED  = 4'h5;
  localparam logic [3:0] MODE_INDIRECT = 4'h8;
  localparam logic [3:0] FORM_BAD_LO   = 4'h5;
  localparam logic [3:0] FORM_BAD_HI   = 4'hF;
  localparam logic [7:0] ENC_OMIT      = 8'hFF;

  localparam logic [3:0] GOOD_MODES [5] = '{MODE_ABS, MODE_PCREL, MODE_TEXTREL,
                                            MODE_DATAREL, MODE_FUNCREL};
  localparam logic [3:0] GOOD_FORMS [9] = '{FORM_NATIVE, FORM_ULEB128, FORM_UDATA2,
                                            FORM_UDATA4, FORM_UDATA8, FORM_SLEB128,
                                            FORM_SDATA2, FORM_SDATA4, FORM_SDATA8};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      quiet     = 1'b0;

  int fail_count;
  int pending_bytes;
  int bytes_checked;
  int error_words;
  int items_sent = 0;
  int stall_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  eh_pointer_byte_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ehpe_byte_checker #(
    .POINTER_BYTES (DEFAULT_POINTER_BYTES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes),
    .bytes_checked (bytes_checked),
    .error_words   (error_words)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0:       return full;
      1:       return 64'($urandom_range(0, 300));
      2:       return -64'($urandom_range(1, 300));
      default: return $signed(full) >>> $urandom_range(0, 63);
    endcase
  endfunction

  // random result stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_pointer(input logic [63:0] value, input logic [7:0] enc,
                              input logic [63:0] pos);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pointer_value: value, encoding: enc, position: pos};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_all_bytes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] value;
    logic [63:0] pos;
    logic [7:0]  enc;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_pointer(64'h0123_4567_89AB_CDEF, {MODE_ABS, FORM_NATIVE}, 64'h0);
    send_pointer(64'h0, {MODE_ABS, FORM_ULEB128}, 64'h0);
    send_pointer(64'd127, {MODE_ABS, FORM_ULEB128}, 64'h0);
    send_pointer(64'd128, {MODE_ABS, FORM_ULEB128}, 64'h0);
    send_pointer('1, {MODE_ABS, FORM_ULEB128}, 64'h0);
    send_pointer(64'h0, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer('1, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(64'd63, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(64'd64, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(-64'd64, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(-64'd65, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(64'h8000_0000_0000_0000, {MODE_ABS, FORM_SLEB128}, 64'h0);
    send_pointer(64'h7FFF_FFFF_FFFF_FFFF, {MODE_ABS, FORM_SLEB128}, '1);
    send_pointer(64'hFEDC_BA98_7654_3210, {MODE_ABS, FORM_UDATA2}, 64'h0);
    send_pointer(64'hFEDC_BA98_7654_3210, {MODE_ABS, FORM_UDATA4}, 64'h0);
    send_pointer(64'hFEDC_BA98_7654_3210, {MODE_ABS, FORM_UDATA8}, 64'h0);
    send_pointer(64'h8000_0000_0000_8001, {MODE_ABS, FORM_SDATA2}, 64'h0);
    send_pointer(64'h8000_0000_8000_0001, {MODE_ABS, FORM_SDATA4}, 64'h0);
    send_pointer(64'h8000_0000_0000_0000, {MODE_ABS, FORM_SDATA8}, 64'h0);
    send_pointer(64'h10, {MODE_PCREL, FORM_UDATA4}, 64'h20);
    send_pointer(64'h1000, {MODE_TEXTREL, FORM_SLEB128}, 64'h1040);
    send_pointer(64'h0, {MODE_DATAREL, FORM_ULEB128}, '1);
    send_pointer(64'h7FFF_FFFF_FFFF_FFFF, {MODE_FUNCREL, FORM_NATIVE}, '1);
    send_pointer(64'h1234, {MODE_ALIGNED, FORM_NATIVE}, 64'h0);
    send_pointer(64'h1234, {MODE_INDIRECT, FORM_UDATA4}, 64'h0);
    send_pointer(64'h1234, ENC_OMIT, 64'h0);
    send_pointer(64'h1234, {MODE_ABS, FORM_BAD_LO}, 64'h0);
    send_pointer(64'h1234, {MODE_PCREL, FORM_BAD_HI}, 64'h0);
    wait_all_bytes();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 30 == 0) quiet <= ((i / 30) % 3 == 1);
      if (i % 40 == 20) wait_all_bytes();
      value = rand_value();
      if ($urandom_range(0, 99) < 85) begin
        enc = {GOOD_MODES[$urandom_range(0, 4)], GOOD_FORMS[$urandom_range(0, 8)]};
      end else begin
        enc = 8'($urandom);
      end
      case ($urandom_range(0, 3))
        0:       pos = {$urandom, $urandom};
        1:       pos = value - 64'($urandom_range(0, 1000));
        2:       pos = value + 64'($urandom_range(0, 1000));
        default: pos = '0;
      endcase
      send_pointer(value, enc, pos);
    end
    quiet <= 1'b0;
    wait_all_bytes();
    repeat (30) @(posedge clk);

    $display("covered %0d pointers over all modes and forms, %0d result bytes checked",
             items_sent, bytes_checked);
    $display("%0d of the checked words were error results", error_words);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d bytes outstanding", pending_bytes);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
